// File: sv/psnr_accumulator_macros.svh
// Assertion macros shared by the PSNR accumulator RTL.
// Depends on nothing; included by the files that assert.
`ifndef PSNR_ACCUMULATOR_MACROS_SVH
`define PSNR_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define PA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psnr_accumulator: check failed");

// next-cycle implication
`define PA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psnr_accumulator: check failed");

`endif

// File: sv/psnr_acc_pkg.sv
// Shared types and constants of the PSNR accumulator.
// Used by the front, queue, back and top level; depends on nothing.
package psnr_acc_pkg;
    localparam int CountBitsDef = 24;
    localparam int SseW         = 40;
    localparam int CountW       = 25;
    localparam int PsnrW        = 15;
    localparam int LogFrac      = 28;
    localparam int NumW         = 42;
    localparam int MsbW         = 6;
    localparam int LogW         = MsbW + LogFrac;
    localparam int KW           = 30;
    localparam int HalfW        = 17;
    localparam logic [PsnrW-1:0] PsnrMax     = 15'h7FFF;
    localparam logic [KW-1:0]    TenLog10Two = 30'd808071242;
    localparam logic [15:0]      PeakSq      = 16'd65025;

    typedef struct packed {
        logic [SseW-1:0]   sse;
        logic [CountW-1:0] count;
        logic              ovf;
    } t_plane;
endpackage

// File: sv/psnr_accumulator.sv
// PSNR accumulator: takes one 8-bit pixel pair per cycle while the plane queue is not full.
// Per plane (marked by last_pixel) it returns SSE, count and PSNR in unsigned Q7.8 dB.
// The PSNR comes from the iterative log2 unit (one normalize shift and one 32x32 squaring
// per cycle, two logs per plane); a zero error sum skips it. A two-entry queue holds
// finished planes, so input stalls only when the queue is full.
module psnr_accumulator import psnr_acc_pkg::*; #(
    parameter int COUNT_BITS = CountBitsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_sample_a,
    input  logic [7:0]        i_sample_b,
    input  logic              i_last_pixel,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PsnrW-1:0]  o_psnr_db,
    output logic [SseW-1:0]   o_squared_error_sum,
    output logic [CountW-1:0] o_pixel_count,
    output logic              o_infinite,
    output logic              o_overflow
);
    logic   full, empty, push, pop;
    t_plane wr_plane, rd_plane;

    psnr_acc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_sample_a   (i_sample_a),
        .i_sample_b   (i_sample_b),
        .i_last_pixel (i_last_pixel),
        .i_full       (full),
        .o_push       (push),
        .o_plane      (wr_plane)
    );

    psnr_acc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_plane (wr_plane),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_plane (rd_plane)
    );

    psnr_acc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_empty             (empty),
        .i_plane             (rd_plane),
        .o_pop               (pop),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_psnr_db           (o_psnr_db),
        .o_squared_error_sum (o_squared_error_sum),
        .o_pixel_count       (o_pixel_count),
        .o_infinite          (o_infinite),
        .o_overflow          (o_overflow)
    );
endmodule

// File: sv/psnr_acc_front.sv
// Front part: accepts pixel pairs, accumulates squared error and count.
// Depends on psnr_acc_pkg; pushes finished plane totals into the queue.
module psnr_acc_front import psnr_acc_pkg::*; #(
    parameter int COUNT_BITS = CountBitsDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_sample_a,
    input  logic [7:0] i_sample_b,
    input  logic       i_last_pixel,
    input  logic       i_full,
    output logic       o_push,
    output t_plane     o_plane
);
`include "psnr_accumulator_macros.svh"

    localparam logic [CountW-1:0] CountCap =
        (COUNT_BITS >= CountW) ? {CountW{1'b1}} : CountW'(64'd1 << COUNT_BITS);

    logic [SseW-1:0]   r_sse, n_sse;
    logic [CountW-1:0] r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic [7:0]        diff;
    logic [15:0]       sq;
    logic [SseW:0]     sum;
    logic              take;

    assign o_ready = !i_full;
    assign take    = i_valid && o_ready;
    assign diff    = (i_sample_a >= i_sample_b) ? i_sample_a - i_sample_b
                                                : i_sample_b - i_sample_a;
    assign sq      = diff * diff;
    assign sum     = {1'b0, r_sse} + {{(SseW-15){1'b0}}, sq};

    always_comb begin
        n_sse = sum[SseW] ? {SseW{1'b1}} : sum[SseW-1:0];
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (r_cnt >= CountCap) begin
            n_ovf = 1'b1;
        end else begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign o_push        = take && i_last_pixel;
    assign o_plane.sse   = n_sse;
    assign o_plane.count = n_cnt;
    assign o_plane.ovf   = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sse <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (take) begin
            if (i_last_pixel) begin
                r_sse <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_sse <= n_sse;
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

    `PA_ASSERT_NOW(a_cnt_capped, i_clk, i_rst_n, 1'b1, r_cnt <= CountCap)
endmodule

// File: sv/psnr_acc_fifo.sv
// Two-entry queue of plane totals between front and back.
// Depends on psnr_acc_pkg for the plane record.
module psnr_acc_fifo import psnr_acc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_plane i_plane,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_plane o_plane
);
`include "psnr_accumulator_macros.svh"

    t_plane     r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_plane = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    `PA_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, i_push, !o_full)
    `PA_ASSERT_NOW(a_no_underrun, i_clk, i_rst_n, i_pop, !o_empty)
endmodule

// File: sv/psnr_acc_back.sv
// Back part: iterative log2 unit, scaling multiply and result register.
// Depends on psnr_acc_pkg; pops plane totals from the queue.
module psnr_acc_back import psnr_acc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_plane            i_plane,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PsnrW-1:0]  o_psnr_db,
    output logic [SseW-1:0]   o_squared_error_sum,
    output logic [CountW-1:0] o_pixel_count,
    output logic              o_infinite,
    output logic              o_overflow
);
`include "psnr_accumulator_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_NORM, S_SQR, S_DIFF, S_MUL_LO, S_MUL_HI, S_ROUND, S_DONE
    } t_state;

    t_state              r_state;
    logic [SseW-1:0]     r_sse;
    logic [CountW-1:0]   r_cnt;
    logic                r_ovf, r_inf, r_den;
    logic [NumW-1:0]     r_x;
    logic [MsbW-1:0]     r_msb;
    logic [31:0]         r_m;
    logic [LogFrac-1:0]  r_frac;
    logic [4:0]          r_it;
    logic [LogW-1:0]     r_ln, r_ld, r_diff;
    logic [63:0]         r_p;
    logic [PsnrW-1:0]    r_psnr;
    logic                r_oval;
    logic [PsnrW-1:0]    r_out_psnr;
    logic [SseW-1:0]     r_out_sse;
    logic [CountW-1:0]   r_out_cnt;
    logic                r_out_inf, r_out_ovf;

    logic [63:0]         sq;
    logic [32:0]         t;
    logic [LogFrac-1:0]  n_frac;
    logic [64:0]         rnd;
    logic [16:0]         q;

    assign sq     = r_m * r_m;
    assign t      = sq[63:31];
    assign n_frac = {r_frac[LogFrac-2:0], t[32]};
    assign rnd    = {1'b0, r_p} + (65'd1 << 47);
    assign q      = rnd[64:48];
    assign o_pop  = (r_state == S_IDLE) && !i_empty;

    assign o_valid             = r_oval;
    assign o_psnr_db           = r_out_psnr;
    assign o_squared_error_sum = r_out_sse;
    assign o_pixel_count       = r_out_cnt;
    assign o_infinite          = r_out_inf;
    assign o_overflow          = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
        end else begin
            if (r_oval && i_ready && (r_state != S_DONE)) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_sse <= i_plane.sse;
                        r_cnt <= i_plane.count;
                        r_ovf <= i_plane.ovf;
                        r_inf <= (i_plane.sse == '0);
                        r_psnr <= PsnrMax;
                        r_state <= (i_plane.sse == '0) ? S_DONE : S_PROD;
                    end
                end
                S_PROD: begin
                    r_x     <= NumW'(r_cnt) * NumW'(PeakSq);
                    r_msb   <= MsbW'(NumW - 1);
                    r_den   <= 1'b0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_x[NumW-1]) begin
                        r_m     <= r_x[NumW-1:NumW-32];
                        r_frac  <= '0;
                        r_it    <= '0;
                        r_state <= S_SQR;
                    end else begin
                        r_x   <= {r_x[NumW-2:0], 1'b0};
                        r_msb <= r_msb - 1'b1;
                    end
                end
                S_SQR: begin
                    r_m    <= t[32] ? t[32:1] : t[31:0];
                    r_frac <= n_frac;
                    r_it   <= r_it + 1'b1;
                    if (r_it == 5'(LogFrac - 1)) begin
                        if (!r_den) begin
                            r_ln    <= {r_msb, n_frac};
                            r_den   <= 1'b1;
                            r_x     <= {{(NumW-SseW){1'b0}}, r_sse};
                            r_msb   <= MsbW'(NumW - 1);
                            r_state <= S_NORM;
                        end else begin
                            r_ld    <= {r_msb, n_frac};
                            r_state <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    if (r_ln <= r_ld) begin
                        r_psnr  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_diff  <= r_ln - r_ld;
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO: begin
                    r_p     <= 64'(r_diff[HalfW-1:0]) * 64'(TenLog10Two);
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_p     <= r_p + ((64'(r_diff[LogW-1:HalfW]) * 64'(TenLog10Two)) << HalfW);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_psnr  <= (q > 17'(PsnrMax)) ? PsnrMax : q[PsnrW-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_oval || i_ready) begin
                        r_oval     <= 1'b1;
                        r_out_psnr <= r_psnr;
                        r_out_sse  <= r_sse;
                        r_out_cnt  <= r_cnt;
                        r_out_inf  <= r_inf;
                        r_out_ovf  <= r_ovf;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PA_ASSERT_NOW(a_inf_max, i_clk, i_rst_n, r_oval && r_out_inf, r_out_psnr == PsnrMax)
    `PA_ASSERT_NOW(a_sqr_bound, i_clk, i_rst_n, r_state == S_SQR, r_it < 5'(LogFrac))
endmodule
